### design/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and constants for the bounded ordered list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bole_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int REQ_W        = 3;
    localparam int IDX_W        = 6;
    localparam int LEN_W        = 7;
    localparam int STAT_W       = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_READ   = 3'd4
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_INS_WRITE,
        S_READ_WAIT
    } state_t;

endpackage

### design/bole_ram.sv
// ----------------------------------------------------------------------------
// bole_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bole_ram
    import bole_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = CAPACITY_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/bounded_ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_unit
// Ordered list of signed 32-bit entries in one RAM, one request per start.
// Search and remove walk the list RAM, one entry per cycle; insert after i
// shifts the entries past i up one place. Busy drops as the strobe rises,
// so the next start is taken in the strobe cycle. Results cannot be stalled.
// Reset clears the length and the controller; list RAM contents are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_ordered_list_engine_unit
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [REQ_W-1:0]         req_type,
    input  logic signed [DATA_W-1:0] value,
    input  logic [IDX_W-1:0]         index,
    output logic                     busy,
    output logic                     strobe,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] data,
    output logic                     found,
    output logic [LEN_W-1:0]         length
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              found_reg, found_next;

    req_t              req_reg;
    logic [DATA_W-1:0] val_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              accept;
    logic              cnt_full;
    logic              cnt_empty;
    logic              idx_bad_in;
    logic              more_shift;
    logic              scan_last;
    logic              scan_hit;

    bole_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_list_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept     = start && (state_reg == S_IDLE);
    assign cnt_full   = cnt_reg >= CW'(CAPACITY);
    assign cnt_empty  = (cnt_reg == '0);
    assign idx_bad_in = XW'(index) >= XW'(cnt_reg);
    assign more_shift = XW'(ptr_reg) > XW'(idx_reg);
    // during the scan, ptr holds the address whose data sits on the RAM read port
    assign scan_last  = (CW'(ptr_reg) + CW'(1)) == cnt_reg;
    assign scan_hit   = (mem_rdata == val_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req_t'(req_type))
                        REQ_INSERT:
                        begin
                            if (!cnt_full && !cnt_empty && !idx_bad_in)
                                state_next = S_SHIFT_UP;
                        end
                        REQ_REMOVE, REQ_SEARCH:
                        begin
                            if (!cnt_empty)
                                state_next = S_SCAN;
                        end
                        REQ_READ:
                        begin
                            if (!cnt_empty && !idx_bad_in)
                                state_next = S_READ_WAIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (req_reg == REQ_SEARCH)
                begin
                    if (scan_hit || scan_last)
                        state_next = S_IDLE;
                end
                else if (scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT_UP:
            begin
                if (!more_shift && !pend_reg)
                    state_next = S_INS_WRITE;
            end
            S_INS_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_READ_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        pend_next   = pend_reg;
        hit_next    = hit_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = val_reg;
        mem_raddr   = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req_t'(req_type))
                        REQ_APPEND:
                        begin
                            done_next  = 1'b1;
                            data_next  = '0;
                            found_next = 1'b0;
                            if (cnt_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                mem_we      = 1'b1;
                                mem_waddr   = AW'(cnt_reg);
                                mem_wdata   = value;
                                cnt_next    = cnt_reg + CW'(1);
                            end
                        end
                        REQ_INSERT:
                        begin
                            data_next  = '0;
                            found_next = 1'b0;
                            if (cnt_full)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else if (cnt_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else if (idx_bad_in)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next  = AW'(cnt_reg - CW'(1));
                                pend_next = 1'b0;
                            end
                        end
                        REQ_REMOVE, REQ_SEARCH:
                        begin
                            data_next  = '0;
                            found_next = 1'b0;
                            if (cnt_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_raddr = '0;
                                ptr_next  = '0;
                                hit_next  = 1'b0;
                            end
                        end
                        REQ_READ:
                        begin
                            data_next  = '0;
                            found_next = 1'b0;
                            if (cnt_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else if (idx_bad_in)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_raddr = AW'(index);
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            data_next   = '0;
                            found_next  = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (req_reg == REQ_SEARCH)
                begin
                    if (scan_hit)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        found_next  = 1'b1;
                    end
                    else if (scan_last)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        mem_raddr = ptr_reg + AW'(1);
                        ptr_next  = ptr_reg + AW'(1);
                    end
                end
                else
                begin
                    // past the match, each entry moves down one place
                    if (hit_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ptr_reg - AW'(1);
                        mem_wdata = mem_rdata;
                    end
                    hit_next = hit_reg || scan_hit;
                    if (scan_last)
                    begin
                        done_next = 1'b1;
                        if (hit_reg || scan_hit)
                        begin
                            status_next = ST_OK;
                            cnt_next    = cnt_reg - CW'(1);
                        end
                        else
                        begin
                            status_next = ST_NOTFOUND;
                        end
                    end
                    else
                    begin
                        mem_raddr = ptr_reg + AW'(1);
                        ptr_next  = ptr_reg + AW'(1);
                    end
                end
            end
            S_SHIFT_UP:
            begin
                // data read last cycle came from ptr+1 and moves up to ptr+2
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg + AW'(2);
                    mem_wdata = mem_rdata;
                end
                if (more_shift)
                begin
                    mem_raddr = ptr_reg;
                    ptr_next  = ptr_reg - AW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_INS_WRITE:
            begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(idx_reg) + AW'(1);
                mem_wdata   = val_reg;
                cnt_next    = cnt_reg + CW'(1);
                done_next   = 1'b1;
                status_next = ST_OK;
            end
            S_READ_WAIT:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                data_next   = mem_rdata;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        if (accept)
        begin
            req_reg <= req_t'(req_type);
            val_reg <= value;
            idx_reg <= index;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = done_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign found  = found_reg;
    assign length = LEN_W'(cnt_reg);

endmodule
